// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define FTM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FTM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/ftm_pkg.sv =====
`timescale 1ns / 1ps
package ftm_pkg;

   localparam int IN_WIDTH  = 24;
   localparam int OUT_WIDTH = 8;

   // Curve constants, value times 2^16 rounded to nearest.
   localparam int K_WIDTH = 18;
   localparam logic [K_WIDTH-1:0] K_A = 18'd164495;
   localparam logic [K_WIDTH-1:0] K_B = 18'd1966;
   localparam logic [K_WIDTH-1:0] K_C = 18'd159252;
   localparam logic [K_WIDTH-1:0] K_D = 18'd38666;
   localparam logic [K_WIDTH-1:0] K_E = 18'd9175;

   localparam int GAMMA_LEVELS = 256;
   localparam int THR_WIDTH    = 17;
   localparam int BIG_WIDTH    = 200;

   typedef logic [THR_WIDTH-1:0] gamma_thr_array_type [GAMMA_LEVELS];

   typedef struct packed {
      logic load;
      logic advance;
   } ftm_ctrl_type;

   // Entry v is the smallest index i with (2v-1)^11 * 2^(5g) <= 510^11 * i^5,
   // so a byte v is reached by every index at or above its entry.
   function automatic gamma_thr_array_type gamma_thr_table(input int g);
      gamma_thr_array_type t;
      logic [BIG_WIDTH-1:0] lhs;
      logic [BIG_WIDTH-1:0] rhs;
      logic [BIG_WIDTH-1:0] k510;
      int lo;
      int hi;
      int mid;
      k510 = BIG_WIDTH'(1);
      for (int k = 0; k < 11; k++) begin
         k510 = k510 * BIG_WIDTH'(510);
      end
      t[0] = '0;
      for (int v = 1; v < GAMMA_LEVELS; v++) begin
         lhs = BIG_WIDTH'(1);
         for (int k = 0; k < 11; k++) begin
            lhs = lhs * BIG_WIDTH'(2 * v - 1);
         end
         lhs = lhs << (5 * g);
         lo = 0;
         hi = 1 << g;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            rhs = k510;
            for (int k = 0; k < 5; k++) begin
               rhs = rhs * BIG_WIDTH'(mid);
            end
            if (lhs <= rhs) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         t[v] = THR_WIDTH'(lo);
      end
      return t;
   endfunction

endpackage

// ===== rtl/filmic_tonemap_gamma_to_rgb8_unit.sv =====
// Stages from an accepted word to its result: three multiply and compare stages, one divider
// stage per quotient bit, a rounding stage and eight gamma search stages. One pixel per clock
// while the output is not stalled, all channels in parallel.
// A stalled output freezes the pipeline; an empty first stage still takes a word.
// Reset clears only the valid bits; the data registers are not reset.
`timescale 1ns / 1ps
module filmic_tonemap_gamma_to_rgb8_unit
   import ftm_pkg::*;
#(
   parameter int INPUT_FRAC_BITS  = 16,
   parameter int GAMMA_INDEX_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [IN_WIDTH-1:0]  req_red_in,
   input  logic [IN_WIDTH-1:0]  req_green_in,
   input  logic [IN_WIDTH-1:0]  req_blue_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_WIDTH-1:0] rsp_red_out,
   output logic [OUT_WIDTH-1:0] rsp_green_out,
   output logic [OUT_WIDTH-1:0] rsp_blue_out
);

   localparam int LATENCY = 3 + (GAMMA_INDEX_BITS + 1) + 1 + OUT_WIDTH;

   ftm_ctrl_type         ctrl;
   logic [LATENCY-1:0]   vld_in, vld_ff;

   assign ctrl.advance = !(vld_ff[LATENCY-1] && rsp_stall);
   assign ctrl.load    = ctrl.advance || !vld_ff[0];
   assign req_stall    = !ctrl.load;
   assign rsp_valid    = vld_ff[LATENCY-1];

   always_comb begin
      if (ctrl.advance) begin
         vld_in = {vld_ff[LATENCY-2:0], req_valid};
      end else if (ctrl.load) begin
         vld_in = {vld_ff[LATENCY-1:1], req_valid};
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   ftm_channel #(
      .INPUT_FRAC_BITS  (INPUT_FRAC_BITS),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_red (
      .clock (clock),
      .ctrl  (ctrl),
      .x     (req_red_in),
      .y     (rsp_red_out)
   );

   ftm_channel #(
      .INPUT_FRAC_BITS  (INPUT_FRAC_BITS),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_green (
      .clock (clock),
      .ctrl  (ctrl),
      .x     (req_green_in),
      .y     (rsp_green_out)
   );

   ftm_channel #(
      .INPUT_FRAC_BITS  (INPUT_FRAC_BITS),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
   ) u_blue (
      .clock (clock),
      .ctrl  (ctrl),
      .x     (req_blue_in),
      .y     (rsp_blue_out)
   );

endmodule

// ===== rtl/ftm_channel.sv =====
`timescale 1ns / 1ps
module ftm_channel
   import ftm_pkg::*;
#(
   parameter int INPUT_FRAC_BITS  = 16,
   parameter int GAMMA_INDEX_BITS = 12
) (
   input  logic                 clock,
   input  ftm_ctrl_type         ctrl,
   input  logic [IN_WIDTH-1:0]  x,
   output logic [OUT_WIDTH-1:0] y
);

   localparam int FB          = INPUT_FRAC_BITS;
   localparam int GB          = GAMMA_INDEX_BITS;
   localparam int INNER_W     = K_WIDTH + IN_WIDTH + 1;
   localparam int HALF_W      = INNER_W - 16;
   localparam int PROD_W      = IN_WIDTH + HALF_W;
   localparam int D_W         = PROD_W + 1;
   localparam int Q_W         = GB + 1;
   localparam int DIV_STEPS   = GB + 1;
   localparam int GAMMA_STEPS = OUT_WIDTH;
   localparam logic [D_W-1:0] E_TERM = D_W'(K_E) << (2 * FB - 16);
   localparam logic [Q_W-1:0] TOP = {1'b0, {GB{1'b1}}};
   localparam gamma_thr_array_type GAMMA_THR = gamma_thr_table(GB);

   // Stage 1: inner linear terms of numerator and denominator.
   logic [INNER_W-1:0] num_sum;
   logic [INNER_W-1:0] den_sum;
   logic [HALF_W-1:0]  na1_in, dc1_in;
   logic [HALF_W-1:0]  na1_ff, dc1_ff;
   logic [IN_WIDTH-1:0] x1_ff;

   assign num_sum = INNER_W'(x) * INNER_W'(K_A) + (INNER_W'(K_B) << FB);
   assign den_sum = INNER_W'(x) * INNER_W'(K_C) + (INNER_W'(K_D) << FB);
   assign na1_in  = num_sum[INNER_W-1:16];
   assign dc1_in  = den_sum[INNER_W-1:16];

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x1_ff  <= x;
         na1_ff <= na1_in;
         dc1_ff <= dc1_in;
      end
   end

   // Stage 2: outer products.
   logic [PROD_W-1:0] n2_in, n2_ff;
   logic [D_W-1:0]    d2_in, d2_ff;

   assign n2_in = PROD_W'(x1_ff) * PROD_W'(na1_ff);
   assign d2_in = D_W'(PROD_W'(x1_ff) * PROD_W'(dc1_ff)) + E_TERM;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         n2_ff <= n2_in;
         d2_ff <= d2_in;
      end
   end

   // Stage 3 and on: overflow compare, then restoring division, one quotient bit per stage.
   logic [D_W-1:0] dr_ff [DIV_STEPS];
   logic [D_W-1:0] dd_ff [DIV_STEPS];
   logic [Q_W-1:0] dq_ff [DIV_STEPS+1];
   logic           ds_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         dr_ff[0] <= D_W'(n2_ff);
         dd_ff[0] <= d2_ff;
         dq_ff[0] <= '0;
         ds_ff[0] <= {1'b0, n2_ff} >= d2_ff;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [D_W:0] shifted;
      logic [D_W:0] diff;
      logic         ge;

      assign shifted = {dr_ff[j], 1'b0};
      assign ge      = shifted >= {1'b0, dd_ff[j]};
      assign diff    = shifted - {1'b0, dd_ff[j]};

      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            dq_ff[j+1] <= {dq_ff[j][Q_W-2:0], ge};
            ds_ff[j+1] <= ds_ff[j];
         end
      end

      if (j < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               dr_ff[j+1] <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
               dd_ff[j+1] <= dd_ff[j];
            end
         end
      end
   end

   // Round the extra quotient bit away and clamp to the top index.
   logic [Q_W:0]   rnd;
   logic [Q_W-1:0] half;
   logic [GB-1:0]  idx_in;
   logic [GB-1:0]  gi_ff [GAMMA_STEPS];

   assign rnd    = (Q_W + 1)'(dq_ff[DIV_STEPS]) + (Q_W + 1)'(1);
   assign half   = rnd[Q_W:1];
   assign idx_in = (ds_ff[DIV_STEPS] || half > TOP) ? TOP[GB-1:0] : half[GB-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         gi_ff[0] <= idx_in;
      end
   end

   // Gamma encoding: binary search of the byte against its threshold table,
   // most significant bit first.
   logic [OUT_WIDTH-1:0] gv_ff [1:GAMMA_STEPS];

   for (genvar s = 0; s < GAMMA_STEPS; s++) begin : g_gamma
      logic [OUT_WIDTH-1:0] base;
      logic [OUT_WIDTH-1:0] cand;
      logic [THR_WIDTH-1:0] thr;
      logic                 take;

      if (s == 0) begin : g_first
         assign base = '0;
      end else begin : g_next
         assign base = gv_ff[s];
      end

      assign cand = base | (OUT_WIDTH'(1) << (OUT_WIDTH - 1 - s));
      assign thr  = GAMMA_THR[cand];
      assign take = thr[GB:0] <= {1'b0, gi_ff[s]};

      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            gv_ff[s+1] <= take ? cand : base;
         end
      end

      if (s < GAMMA_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               gi_ff[s+1] <= gi_ff[s];
            end
         end
      end
   end

   assign y = gv_ff[GAMMA_STEPS];

endmodule

// ===== rtl/ftm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ftm_checker
   import ftm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OUT_WIDTH-1:0] rsp_red_out,
   input logic [OUT_WIDTH-1:0] rsp_green_out,
   input logic [OUT_WIDTH-1:0] rsp_blue_out
);

   logic [3*OUT_WIDTH-1:0] rsp_word;

   assign rsp_word = {rsp_red_out, rsp_green_out, rsp_blue_out};

   // A waiting result stays offered and unchanged until it is taken.
   `FTM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `FTM_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_word), "stalled result changed")

   // The input side only waits when a result is blocked at the output.
   `FTM_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "input stall without output stall")

   // Reset empties the pipeline.
   `FTM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result offered right after reset")

endmodule

bind filmic_tonemap_gamma_to_rgb8_unit ftm_checker u_ftm_checker (.*);
